[hdl/rbst_pkg.sv]
package rbst_pkg;

   localparam int AXES    = 3;
   localparam int Q_W     = 32;
   localparam int FRAC_W  = 16;
   localparam int DIFF_W  = Q_W + 1;
   localparam int NUM_W   = DIFF_W + FRAC_W;
   localparam int DEN_W   = Q_W;
   localparam int T_W     = NUM_W + 2;
   localparam int STEPS   = NUM_W;
   localparam int DIV_LAT = STEPS + 2;
   localparam int LAT     = DIV_LAT + 3;
   localparam int REQ_W   = 4 * AXES * Q_W;
   localparam int RSP_W   = 40;

   localparam logic signed [T_W-1:0] T_NEG_INF = {1'b1, {(T_W-1){1'b0}}};
   localparam logic signed [T_W-1:0] T_POS_INF = {1'b0, {(T_W-1){1'b1}}};
   localparam logic signed [T_W-1:0] T_Q_MAX   = T_W'({1'b0, {(Q_W-1){1'b1}}});
   localparam logic signed [T_W-1:0] T_Q_MIN   = -T_Q_MAX - T_W'(1);
   localparam logic signed [Q_W-1:0] Q_MAX     = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN     = {1'b1, {(Q_W-1){1'b0}}};

   typedef struct packed {
      logic [AXES-1:0] dir_zero;
      logic            miss;
   } side_type;

endpackage

[hdl/ray_box_slab_test_top.sv]
// channel  direction  item
// req      in         ray origin, direction and box corners, 12 x Q16.16
// rsp      out        hit flag and saturated entry distance
//
// one item per cycle while the pipeline is not held, results pass through the 49-step divider pipeline
// reset clears only the valid bits, payload registers are not reset
// the whole pipeline holds while a result waits and rsp_tready is low
module ray_box_slab_test_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // origin_x/y/z, dir_x/y/z, box_min_x/y/z, box_max_x/y/z, 32 bits each
   input  logic [rbst_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit, entry_distance[32:1], zero fill
   output logic [rbst_pkg::RSP_W-1:0] rsp_tdata
);
   import rbst_pkg::*;

   logic enable;
   logic valid_ff [0:LAT-1];
   side_type side_ff [0:DIV_LAT-1];
   side_type side_in;
   logic signed [T_W-1:0] quo [0:AXES-1][0:1];

   logic signed [T_W-1:0] tn_ff [0:AXES-1];
   logic signed [T_W-1:0] tf_ff [0:AXES-1];
   logic signed [T_W-1:0] tn_in [0:AXES-1];
   logic signed [T_W-1:0] tf_in [0:AXES-1];
   logic                  miss1_ff, miss2_ff;
   logic signed [T_W-1:0] entry_ff, exit_ff, entry_in, exit_in;
   logic                  hit_ff;
   logic signed [Q_W-1:0] dist_ff;

   assign rsp_tvalid = valid_ff[LAT-1];
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   genvar a, s;
   generate
      for (a = 0; a < AXES; a++) begin : g_axis
         logic signed [Q_W-1:0] org, dir, lo, hi;
         logic [DEN_W-1:0]      den;
         assign org = req_tdata[a*Q_W +: Q_W];
         assign dir = req_tdata[(AXES+a)*Q_W +: Q_W];
         assign lo  = req_tdata[(2*AXES+a)*Q_W +: Q_W];
         assign hi  = req_tdata[(3*AXES+a)*Q_W +: Q_W];
         assign den = dir[Q_W-1] ? DEN_W'(-dir) : DEN_W'(dir);
         for (s = 0; s < 2; s++) begin : g_plane
            logic signed [DIFF_W-1:0] diff;
            logic [DIFF_W-1:0]        dmag;
            assign diff = (s == 0) ? ($signed({lo[Q_W-1], lo}) - $signed({org[Q_W-1], org}))
                                   : ($signed({hi[Q_W-1], hi}) - $signed({org[Q_W-1], org}));
            assign dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            rbst_div u_div (
               .clock   (clock),
               .enable  (enable),
               .num_mag ({dmag, {FRAC_W{1'b0}}}),
               .den_mag (den),
               .neg     (diff[DIFF_W-1] ^ dir[Q_W-1]),
               .quo     (quo[a][s])
            );
         end
      end
   endgenerate

   always_comb begin
      side_in.miss = 1'b0;
      for (int k = 0; k < AXES; k++) begin
         side_in.dir_zero[k] = (req_tdata[(AXES+k)*Q_W +: Q_W] == '0);
         if (side_in.dir_zero[k] &&
             (($signed(req_tdata[k*Q_W +: Q_W]) < $signed(req_tdata[(2*AXES+k)*Q_W +: Q_W])) ||
              ($signed(req_tdata[k*Q_W +: Q_W]) > $signed(req_tdata[(3*AXES+k)*Q_W +: Q_W]))))
            side_in.miss = 1'b1;
      end
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         if (side_ff[DIV_LAT-1].dir_zero[k]) begin
            tn_in[k] = T_NEG_INF;
            tf_in[k] = T_POS_INF;
         end else if (quo[k][0] < quo[k][1]) begin
            tn_in[k] = quo[k][0];
            tf_in[k] = quo[k][1];
         end else begin
            tn_in[k] = quo[k][1];
            tf_in[k] = quo[k][0];
         end
      end
      entry_in = tn_ff[0];
      exit_in  = tf_ff[0];
      for (int k = 1; k < AXES; k++) begin
         if (tn_ff[k] > entry_in) entry_in = tn_ff[k];
         if (tf_ff[k] < exit_in)  exit_in  = tf_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) valid_ff[k] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= req_tvalid;
         for (int k = 1; k < LAT; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_LAT; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 0; k < AXES; k++) begin
            tn_ff[k] <= tn_in[k];
            tf_ff[k] <= tf_in[k];
         end
         miss1_ff <= side_ff[DIV_LAT-1].miss;
         entry_ff <= entry_in;
         exit_ff  <= exit_in;
         miss2_ff <= miss1_ff;
         if (miss2_ff) begin
            hit_ff  <= 1'b0;
            dist_ff <= Q_MAX;
         end else begin
            hit_ff <= (exit_ff >= entry_ff) && (entry_ff > 0);
            if (entry_ff > T_Q_MAX)      dist_ff <= Q_MAX;
            else if (entry_ff < T_Q_MIN) dist_ff <= Q_MIN;
            else                         dist_ff <= entry_ff[Q_W-1:0];
         end
      end
   end

   assign rsp_tdata = {{(RSP_W-Q_W-1){1'b0}}, dist_ff, hit_ff};

endmodule

[hdl/rbst_div.sv]
module rbst_div (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [rbst_pkg::NUM_W-1:0]         num_mag,
   input  logic [rbst_pkg::DEN_W-1:0]         den_mag,
   input  logic                               neg,
   output logic signed [rbst_pkg::T_W-1:0]    quo
);
   import rbst_pkg::*;

   logic [DEN_W-1:0] rem_ff [0:STEPS];
   logic [NUM_W-1:0] q_ff   [0:STEPS];
   logic [DEN_W-1:0] den_ff [0:STEPS];
   logic             neg_ff [0:STEPS];
   logic [DEN_W-1:0] rem_in [1:STEPS];
   logic [NUM_W-1:0] q_in   [1:STEPS];
   logic signed [T_W-1:0] quo_ff;
   logic signed [T_W-1:0] mag;

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         logic [DEN_W:0] trial;
         logic [DEN_W:0] sub;
         logic           ge;
         always_comb begin
            trial = {rem_ff[i], q_ff[i][NUM_W-1]};
            sub   = trial - {1'b0, den_ff[i]};
            ge    = trial >= {1'b0, den_ff[i]};
            rem_in[i+1] = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
            q_in[i+1]   = {q_ff[i][NUM_W-2:0], ge};
         end
      end
   endgenerate

   assign mag = $signed({{(T_W-NUM_W){1'b0}}, q_ff[STEPS]});

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= '0;
         q_ff[0]   <= num_mag;
         den_ff[0] <= den_mag;
         neg_ff[0] <= neg;
         for (int k = 1; k <= STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
         quo_ff <= neg_ff[STEPS] ? -mag : mag;
      end
   end

   assign quo = quo_ff;

endmodule
